### hdl/oaids_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oaids_pkg: shared types and constants for the ordered array block
// Holds the capacity, the derived index and count widths, the request and
// response beat types and the per-cell control group.
// ----------------------------------------------------------------------------
package oaids_pkg;

   localparam int CAPACITY  = 128;
   localparam int WORD_W    = 32;
   localparam int IDX_W     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W     = $clog2(CAPACITY + 1);
   localparam int TREE_SIZE = 1 << IDX_W;
   localparam int CMP_W     = (CNT_W > 8) ? CNT_W : 8;

   typedef enum logic [1:0] {
      KIND_CLEAR  = 2'd0,
      KIND_INSERT = 2'd1,
      KIND_DELETE = 2'd2,
      KIND_SEARCH = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ST_DONE     = 2'd0,
      ST_BAD_POS  = 2'd1,
      ST_NOTFOUND = 2'd2
   } status_type;

   typedef struct packed {
      kind_type           kind;
      logic signed [31:0] item_value;
      logic [7:0]         position;
   } req_type;

   typedef struct packed {
      status_type status;
      logic [6:0] found_index;
      logic [7:0] element_total;
   } rsp_type;

   // Per-cell load selects for one update cycle
   typedef struct packed {
      logic load_word;
      logic load_left;
      logic load_right;
   } cell_ctl_type;

endpackage

### hdl/ordered_array_insert_delete_search.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_array_insert_delete_search: ordered word array with clear, insert,
// delete by value and search
// A chain of storage cells, one per entry, with a priority tree that picks
// the first matching entry.
// ----------------------------------------------------------------------------
// The block takes no new request while busy is high. A request is taken on
// a rising edge with start high and busy low; busy is then high for one
// cycle. In the cycle of acceptance every
// cell compares its word with the request word; in the busy cycle the
// priority tree picks the lowest matching entry and the chain shifts up
// (insert) or down (delete) by one place at the end of that cycle. The
// response beat appears on rsp_item with rsp_valid high for exactly one cycle,
// the cycle after busy; a new request may be started in that same cycle. The
// receiver cannot hold the response off, so sample it whenever rsp_valid is
// high. After reset the array is empty; no clearing pass is needed.
// ----------------------------------------------------------------------------
module ordered_array_insert_delete_search
   import oaids_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_item,
   output logic    rsp_valid,
   output rsp_type rsp_item
);

   typedef enum logic {
      S_IDLE,
      S_RESOLVE
   } state_type;

   state_type        state_ff, state_in;
   req_type          req_ff, req_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   logic                accept;
   logic                resolve;
   logic [CAPACITY-1:0] in_range;
   logic [CAPACITY-1:0] match_vec;
   logic [WORD_W-1:0]   cell_word [0:CAPACITY-1];
   cell_ctl_type        cell_ctl  [0:CAPACITY-1];
   logic                hit;
   logic [IDX_W-1:0]    hit_idx;
   logic [CMP_W-1:0]    pos_ext;
   logic [CMP_W-1:0]    cnt_ext;
   logic                ins_go;
   logic                del_go;
   logic [IDX_W+6:0]    hit_wide;
   logic [CNT_W+7:0]    total_wide;

   assign accept  = start && (state_ff == S_IDLE);
   assign resolve = (state_ff == S_RESOLVE);

   // Insert is legal when the position is at or below the count and room is left
   assign pos_ext = CMP_W'(req_ff.position);
   assign cnt_ext = CMP_W'(count_ff);
   assign ins_go  = resolve && (req_ff.kind == KIND_INSERT) && (pos_ext <= cnt_ext)
                    && (count_ff != CNT_W'(CAPACITY));
   assign del_go  = resolve && (req_ff.kind == KIND_DELETE) && hit;

   // Cell chain: each cell compares in the accept cycle and shifts in the resolve cycle
   genvar i;
   generate
      for (i = 0; i < CAPACITY; i++) begin : g_cell
         logic [WORD_W-1:0] left_word;
         logic [WORD_W-1:0] right_word;

         assign in_range[i] = count_ff > CNT_W'(i);

         if (i == 0) begin : g_first
            assign left_word = cell_word[i];
         end else begin : g_left
            assign left_word = cell_word[i-1];
         end

         if (i == CAPACITY - 1) begin : g_last
            assign right_word          = cell_word[i];
            assign cell_ctl[i].load_right = 1'b0;
         end else begin : g_right
            assign right_word          = cell_word[i+1];
            // close the gap from the deleted entry upward
            assign cell_ctl[i].load_right = del_go && (hit_idx <= IDX_W'(i));
         end

         assign cell_ctl[i].load_word = ins_go && (pos_ext == CMP_W'(i));
         // shift entries above the insert position up one place
         assign cell_ctl[i].load_left = ins_go && (pos_ext < CMP_W'(i));

         oaids_cell u_cell (
            .clock      (clock),
            .capture    (accept),
            .cmp_word   (req_item.item_value),
            .in_range   (in_range[i]),
            .ctl        (cell_ctl[i]),
            .new_word   (req_ff.item_value),
            .left_word  (left_word),
            .right_word (right_word),
            .word       (cell_word[i]),
            .match      (match_vec[i])
         );
      end
   endgenerate

   oaids_first_match u_first_match (
      .match_vec (match_vec),
      .hit       (hit),
      .hit_idx   (hit_idx)
   );

   assign hit_wide = {7'd0, hit_idx};

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      count_in     = count_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      total_wide   = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               req_in   = req_item;
               state_in = S_RESOLVE;
            end
         end
         S_RESOLVE: begin
            rsp_in.status      = ST_DONE;
            rsp_in.found_index = 7'd0;
            unique case (req_ff.kind) inside
               KIND_CLEAR: begin
                  count_in = '0;
               end
               KIND_INSERT: begin
                  if (ins_go) begin
                     count_in           = count_ff + CNT_W'(1);
                     rsp_in.found_index = req_ff.position[6:0];
                  end else begin
                     rsp_in.status = ST_BAD_POS;
                  end
               end
               KIND_DELETE, KIND_SEARCH: begin
                  if (hit) begin
                     rsp_in.found_index = hit_wide[6:0];
                     if (req_ff.kind == KIND_DELETE) begin
                        count_in = count_ff - CNT_W'(1);
                     end
                  end else begin
                     rsp_in.status = ST_NOTFOUND;
                  end
               end
               default: begin
                  count_in = count_ff;
               end
            endcase
            total_wide           = {8'd0, count_in};
            rsp_in.element_total = total_wide[7:0];
            rsp_valid_in         = 1'b1;
            state_in             = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   // Every taken request gives exactly one response beat, after its resolve cycle
   assert property (@(posedge clock) disable iff (reset)
      accept |=> ##1 rsp_valid)
      else $error("request taken without a response beat");

   // A response beat only follows a resolve cycle
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(resolve))
      else $error("response beat without a resolve cycle");

   // The element count never passes the capacity
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("element count above capacity");

   // The count changes only on the resolve edge; a clear may drop it to zero
   assert property (@(posedge clock) disable iff (reset)
      !resolve |=> $stable(count_ff))
      else $error("element count changed outside a resolve cycle");

endmodule

### hdl/oaids_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oaids_cell: one storage cell of the ordered array chain
// Holds one word, compares it with the request word and loads the new
// word or a neighbor's word when the array shifts.
// ----------------------------------------------------------------------------
module oaids_cell
   import oaids_pkg::*;
(
   input  logic              clock,
   input  logic              capture,
   input  logic [WORD_W-1:0] cmp_word,
   input  logic              in_range,
   input  cell_ctl_type      ctl,
   input  logic [WORD_W-1:0] new_word,
   input  logic [WORD_W-1:0] left_word,
   input  logic [WORD_W-1:0] right_word,
   output logic [WORD_W-1:0] word,
   output logic              match
);

   logic [WORD_W-1:0] word_ff;
   logic [WORD_W-1:0] word_in;
   logic              match_ff;
   logic              match_in;

   always_comb begin
      word_in = word_ff;
      if (ctl.load_word) begin
         word_in = new_word;
      end else if (ctl.load_left) begin
         word_in = left_word;
      end else if (ctl.load_right) begin
         word_in = right_word;
      end
      // hold the compare result until the next request is taken
      match_in = capture ? (in_range && (word_ff == cmp_word)) : match_ff;
   end

   always_ff @(posedge clock) begin
      word_ff  <= word_in;
      match_ff <= match_in;
   end

   assign word  = word_ff;
   assign match = match_ff;

endmodule

### hdl/oaids_first_match.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oaids_first_match: lowest-index priority tree over the cell match flags
// Binary tree of log2 depth; each node passes up the left child when it hits.
// ----------------------------------------------------------------------------
module oaids_first_match
   import oaids_pkg::*;
(
   input  logic [CAPACITY-1:0] match_vec,
   output logic                hit,
   output logic [IDX_W-1:0]    hit_idx
);

   logic             node_hit [1:2*TREE_SIZE-1];
   logic [IDX_W-1:0] node_idx [1:2*TREE_SIZE-1];

   genvar g;
   generate
      for (g = 0; g < TREE_SIZE; g++) begin : g_leaf
         if (g < CAPACITY) begin : g_real
            assign node_hit[TREE_SIZE + g] = match_vec[g];
         end else begin : g_pad
            assign node_hit[TREE_SIZE + g] = 1'b0;
         end
         assign node_idx[TREE_SIZE + g] = IDX_W'(g);
      end
      for (g = 1; g < TREE_SIZE; g++) begin : g_node
         assign node_hit[g] = node_hit[2*g] | node_hit[2*g + 1];
         assign node_idx[g] = node_hit[2*g] ? node_idx[2*g] : node_idx[2*g + 1];
      end
   endgenerate

   assign hit     = node_hit[1];
   assign hit_idx = node_idx[1];

endmodule
